FILE: rtl/rwsp_pkg.sv
// Shared types, constants and the sequencer microcode for the register write log player.
// No dependencies; imported by rwsp_seq, register_write_sequence_player and the bench.
package rwsp_pkg;

  localparam int STORE_DEPTH         = 4096;
  localparam int ADDR_W              = $clog2(STORE_DEPTH);
  localparam int MAX_WRITES_PER_TICK = 64;
  localparam int BUDGET_W            = $clog2(MAX_WRITES_PER_TICK + 1);
  localparam int PTR_W               = 13;
  localparam int WAIT_W              = 16;
  localparam int LEN_W               = 13;

  localparam logic [7:0] KEYOFF_LO   = 8'hB0;
  localparam logic [7:0] KEYOFF_HI   = 8'hB8;
  localparam logic [7:0] KEYON_MASK  = 8'h20;
  localparam logic [7:0] LOOP_MARK   = 8'hFF;
  localparam int         PKT_LAST_OFF = 3;
  localparam int         PKT_BYTES    = 4;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_START = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'd0,
    S_DEC  = 4'd1,
    S_CHK  = 4'd2,
    S_R1   = 4'd3,
    S_R2   = 4'd4,
    S_R3   = 4'd5,
    S_EVAL = 4'd6,
    S_EOD  = 4'd7,
    S_FIN  = 4'd8
  } step_t;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_DEC   = 3'd1,
    OP_EVAL  = 3'd2,
    OP_EOD   = 3'd3,
    OP_FLUSH = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    J_WAIT = 2'd0,  // hold until a tick is taken, then go to target
    J_SEQ  = 2'd1,
    J_GOTO = 2'd2,
    J_CHK  = 2'd3   // done -> target, end of data -> S_EOD, else next
  } jmp_t;

  typedef enum logic [1:0] {
    CAP_NONE = 2'd0,
    CAP_REG  = 2'd1,
    CAP_VAL  = 2'd2,
    CAP_DLO  = 2'd3
  } cap_t;

  typedef struct packed {
    logic       rd_en;
    logic [1:0] rd_off;
    cap_t       cap;
    op_t        op;
    jmp_t       jmp;
    step_t      target;
  } uword_t;

  typedef struct packed {
    logic go;
    logic done;
    logic eod;
  } cond_t;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{rd_en: 1'b0, rd_off: 2'd0, cap: CAP_NONE, op: OP_NONE, jmp: J_GOTO, target: S_IDLE};
    case (s)
      S_IDLE: begin
        w.jmp = J_WAIT; w.target = S_DEC;
      end
      S_DEC: begin
        w.op = OP_DEC; w.jmp = J_SEQ;
      end
      S_CHK: begin
        w.rd_en = 1'b1; w.rd_off = 2'd0; w.jmp = J_CHK; w.target = S_FIN;
      end
      S_R1: begin
        w.rd_en = 1'b1; w.rd_off = 2'd1; w.cap = CAP_REG; w.jmp = J_SEQ;
      end
      S_R2: begin
        w.rd_en = 1'b1; w.rd_off = 2'd2; w.cap = CAP_VAL; w.jmp = J_SEQ;
      end
      S_R3: begin
        w.rd_en = 1'b1; w.rd_off = 2'd3; w.cap = CAP_DLO; w.jmp = J_SEQ;
      end
      S_EVAL: begin
        w.op = OP_EVAL; w.target = S_CHK;
      end
      S_EOD: begin
        w.op = OP_EOD; w.target = S_FIN;
      end
      S_FIN: begin
        w.op = OP_FLUSH; w.target = S_IDLE;
      end
      default: begin
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/rwsp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rwsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/rwsp_seq.sv
// Microcode sequencer: step counter, control word ROM and conditional jumps.
// Depends on rwsp_pkg.
module rwsp_seq import rwsp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cond_t  cond,
  output step_t  step,
  output uword_t ctl,
  output logic   busy
);

  step_t upc_r, upc_nxt;

  // next step
  always_comb begin
    upc_nxt = upc_r;
    case (ctl.jmp)
      J_WAIT: upc_nxt = cond.go ? ctl.target : upc_r;
      J_SEQ:  upc_nxt = step_t'(upc_r + 4'd1);
      J_GOTO: upc_nxt = ctl.target;
      J_CHK: begin
        if (cond.done) begin
          upc_nxt = ctl.target;
        end else if (cond.eod) begin
          upc_nxt = S_EOD;
        end else begin
          upc_nxt = step_t'(upc_r + 4'd1);
        end
      end
      default: upc_nxt = S_IDLE;
    endcase
  end

  // control word
  always_comb begin
    ctl  = ucode(upc_r);
    busy = (upc_r != S_IDLE);
    step = upc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

FILE: rtl/register_write_sequence_player.sv
// Top level: plays a stored log of sound-chip register writes packet by packet on each tick.
// Depends on rwsp_pkg, rwsp_ram and rwsp_seq.
//
//   channel   handshake            payload
//   input     start / busy         in_cmd, in_load_addr, in_load_byte
//   result    out_valid (strobe)   out_kind, out_write_reg, out_write_value,
//                                  out_now_playing, out_last
//   config    cfg_valid/cfg_ready  cfg_song_length
//
// Load, start and stop do not raise busy; start/stop show their chip clear the next cycle.
// A tick holds busy while it reads up to MAX_WRITES_PER_TICK packets, one more step when
// the data runs out; each packet takes the four single-port store reads plus one
// evaluate step. Its final result shows in the first cycle with busy low.
// Each result is held back until the next one so the final one can carry out_last.
// Reset is synchronous; the store is not cleared. Results cannot be stalled.
module register_write_sequence_player import rwsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_cmd,
  input  logic [11:0]       in_load_addr,
  input  logic [7:0]        in_load_byte,
  output logic              out_valid,
  output logic              out_kind,
  output logic [7:0]        out_write_reg,
  output logic [7:0]        out_write_value,
  output logic              out_now_playing,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_song_length
);

  uword_t ctl;
  cond_t  cond;
  step_t  step;

  logic [PTR_W-1:0]    rp_r, rp_nxt;
  logic [WAIT_W-1:0]   wait_r, wait_nxt;
  logic                playing_r, playing_nxt;
  logic                looped_r, looped_nxt;
  logic [BUDGET_W-1:0] budget_r, budget_nxt;
  logic [LEN_W-1:0]    song_len_r;
  logic [7:0]          reg_r, val_r, dlo_r;

  logic                pend_v_r, pend_v_nxt;
  logic                pend_kind_r, pend_kind_nxt;
  logic [7:0]          pend_reg_r, pend_reg_nxt;
  logic [7:0]          pend_val_r, pend_val_nxt;
  logic                pend_play_r, pend_play_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_kind_r, out_kind_nxt;
  logic [7:0]          out_reg_r, out_reg_nxt;
  logic [7:0]          out_val_r, out_val_nxt;
  logic                out_play_r, out_play_nxt;
  logic                out_last_r, out_last_nxt;

  logic                accept;
  cmd_t                cmd;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [7:0]          ram_rdata;
  logic [PTR_W:0]      rd_sum;
  logic [PTR_W:0]      end_sum;
  logic [WAIT_W-1:0]   delay;
  logic                skip;

  logic                new_v;
  logic                new_kind;
  logic [7:0]          new_reg;
  logic [7:0]          new_val;
  logic                new_play;

  assign accept    = start && !busy;
  assign cmd       = cmd_t'(in_cmd);
  assign cfg_ready = 1'b1;
  assign ram_we    = accept && (cmd == CMD_LOAD);

  assign rd_sum    = {1'b0, rp_r} + {{(PTR_W - 1){1'b0}}, ctl.rd_off};
  assign ram_raddr = ADDR_W'(rd_sum);

  rwsp_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(in_load_addr)),
    .wdata (in_load_byte),
    .re    (ctl.rd_en),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign end_sum    = {1'b0, rp_r} + (PTR_W + 1)'(PKT_LAST_OFF);
  assign cond.go    = accept && (cmd == CMD_TICK) && playing_r;
  assign cond.done  = (wait_r != '0) || (budget_r == BUDGET_W'(MAX_WRITES_PER_TICK));
  assign cond.eod   = (end_sum >= {1'b0, song_len_r});

  rwsp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .step  (step),
    .ctl   (ctl),
    .busy  (busy)
  );

  // high delay byte comes straight from the store in the evaluate step
  assign delay = {ram_rdata, dlo_r};
  assign skip  = looped_r && (reg_r >= KEYOFF_LO) && (reg_r <= KEYOFF_HI) &&
                 ((val_r & KEYON_MASK) == 8'h00) && (delay <= WAIT_W'(1));

  always_comb begin
    rp_nxt        = rp_r;
    wait_nxt      = wait_r;
    playing_nxt   = playing_r;
    looped_nxt    = looped_r;
    budget_nxt    = budget_r;
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_reg_nxt  = pend_reg_r;
    pend_val_nxt  = pend_val_r;
    pend_play_nxt = pend_play_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_reg_nxt   = out_reg_r;
    out_val_nxt   = out_val_r;
    out_play_nxt  = out_play_r;
    out_last_nxt  = out_last_r;
    new_v         = 1'b0;
    new_kind      = KIND_WRITE;
    new_reg       = reg_r;
    new_val       = val_r;
    new_play      = playing_r;

    if (accept && (cmd == CMD_START || cmd == CMD_STOP)) begin
      playing_nxt   = (cmd == CMD_START);
      looped_nxt    = 1'b0;
      rp_nxt        = '0;
      wait_nxt      = '0;
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_CLEAR;
      out_reg_nxt   = 8'h00;
      out_val_nxt   = 8'h00;
      out_play_nxt  = (cmd == CMD_START);
      out_last_nxt  = 1'b1;
    end

    case (ctl.op)
      OP_DEC: begin
        if (wait_r != '0) begin
          wait_nxt = wait_r - WAIT_W'(1);
        end
        budget_nxt = '0;
      end
      OP_EVAL: begin
        rp_nxt     = rp_r + PTR_W'(PKT_BYTES);
        budget_nxt = budget_r + BUDGET_W'(1);
        looped_nxt = 1'b0;
        if (!skip) begin
          if (reg_r == LOOP_MARK && val_r == LOOP_MARK) begin
            rp_nxt     = '0;
            looped_nxt = 1'b1;
          end else begin
            wait_nxt = delay;
            new_v    = 1'b1;
            new_kind = KIND_WRITE;
            new_reg  = reg_r;
            new_val  = val_r;
            new_play = playing_r;
          end
        end
      end
      OP_EOD: begin
        playing_nxt = 1'b0;
        looped_nxt  = 1'b0;
        rp_nxt      = '0;
        wait_nxt    = '0;
        new_v       = 1'b1;
        new_kind    = KIND_CLEAR;
        new_reg     = 8'h00;
        new_val     = 8'h00;
        new_play    = 1'b0;
      end
      OP_FLUSH: begin
        if (pend_v_r) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = pend_kind_r;
          out_reg_nxt   = pend_reg_r;
          out_val_nxt   = pend_val_r;
          out_play_nxt  = pend_play_r;
          out_last_nxt  = 1'b1;
        end
        pend_v_nxt = 1'b0;
      end
      default: begin
      end
    endcase

    // a new result pushes the held one out as not-last
    if (new_v) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = pend_kind_r;
        out_reg_nxt   = pend_reg_r;
        out_val_nxt   = pend_val_r;
        out_play_nxt  = pend_play_r;
        out_last_nxt  = 1'b0;
      end
      pend_v_nxt    = 1'b1;
      pend_kind_nxt = new_kind;
      pend_reg_nxt  = new_reg;
      pend_val_nxt  = new_val;
      pend_play_nxt = new_play;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r        <= '0;
      wait_r      <= '0;
      playing_r   <= 1'b0;
      looped_r    <= 1'b0;
      budget_r    <= '0;
      song_len_r  <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rp_r        <= rp_nxt;
      wait_r      <= wait_nxt;
      playing_r   <= playing_nxt;
      looped_r    <= looped_nxt;
      budget_r    <= budget_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        song_len_r <= cfg_song_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.cap)
      CAP_REG: reg_r <= ram_rdata;
      CAP_VAL: val_r <= ram_rdata;
      CAP_DLO: dlo_r <= ram_rdata;
      default: begin
      end
    endcase
    pend_kind_r <= pend_kind_nxt;
    pend_reg_r  <= pend_reg_nxt;
    pend_val_r  <= pend_val_nxt;
    pend_play_r <= pend_play_nxt;
    out_kind_r  <= out_kind_nxt;
    out_reg_r   <= out_reg_nxt;
    out_val_r   <= out_val_nxt;
    out_play_r  <= out_play_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_write_reg   = out_reg_r;
  assign out_write_value = out_val_r;
  assign out_now_playing = out_play_r;
  assign out_last        = out_last_r;

  // register writes only come out while playing
  a_write_playing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_WRITE) |-> out_now_playing)
    else $error("register write emitted while stopped");

  // a clear that leaves playback stopped always ends its item
  a_stop_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_CLEAR) && !out_now_playing |-> out_last)
    else $error("stopping chip clear not marked last");

  // nothing is shown in the first cycle of a tick
  a_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> !out_valid)
    else $error("result shown as a tick starts");

  // the packet budget is never exceeded
  a_budget: assert property (@(posedge clk) disable iff (!rst_n)
    (step == S_EVAL) |-> (budget_r < BUDGET_W'(MAX_WRITES_PER_TICK)))
    else $error("packet budget overrun");

endmodule

FILE: dv/player_check_pkg.sv
`timescale 1ns / 1ps
// Expected-write predictor and output checker for the register write log player bench.
// Depends on rwsp_pkg from the RTL.
package player_check_pkg;
  import rwsp_pkg::*;

  typedef struct {
    logic       kind;
    logic [7:0] regno;
    logic [7:0] value;
    logic       playing;
    logic       last;
  } chip_write_t;

  localparam int SHOWN_MISMATCHES = 40;

  class player_scoreboard;
    bit [7:0]        log_bytes [STORE_DEPTH];
    bit              loaded    [STORE_DEPTH];
    bit [PTR_W-1:0]  cursor;
    bit [WAIT_W-1:0] hold;
    bit              running;
    bit              after_loop;
    bit [LEN_W-1:0]  song_len;
    chip_write_t     due_writes [$];
    int              mismatches;

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= SHOWN_MISMATCHES) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Plays one tick on copies of the state. Returns the first store address the tick
    // would read before it was ever loaded, or -1. State and writes are kept only on commit.
    function int advance_frame(bit commit);
      bit [PTR_W-1:0]  ptr    = cursor;
      bit [WAIT_W-1:0] cnt    = hold;
      bit              on     = running;
      bit              looped = after_loop;
      chip_write_t     batch [$];
      chip_write_t     w;
      bit [7:0]        r;
      bit [7:0]        v;
      bit [15:0]       dly;
      bit [ADDR_W-1:0] a;
      int              steps;
      if (!on) return -1;
      if (cnt != 0) cnt--;
      steps = 0;
      while (cnt == 0 && steps < MAX_WRITES_PER_TICK) begin
        steps++;
        if (int'(ptr) + PKT_LAST_OFF >= int'(song_len)) begin
          on = 1'b0;
          looped = 1'b0;
          ptr = '0;
          cnt = '0;
          w = '{kind: KIND_CLEAR, regno: 8'h00, value: 8'h00, playing: 1'b0, last: 1'b0};
          batch.push_back(w);
          break;
        end
        for (int k = 0; k < PKT_BYTES; k++) begin
          a = ADDR_W'(int'(ptr) + k);
          if (!loaded[a]) return int'(a);
        end
        a = ADDR_W'(ptr);
        r = log_bytes[a];
        v = log_bytes[ADDR_W'(int'(ptr) + 1)];
        dly = {log_bytes[ADDR_W'(int'(ptr) + 3)], log_bytes[ADDR_W'(int'(ptr) + 2)]};
        ptr = ptr + PTR_W'(PKT_BYTES);
        // key-off right after a loop is dropped
        if (looped && r >= KEYOFF_LO && r <= KEYOFF_HI &&
            (v & KEYON_MASK) == 8'h00 && dly <= 16'd1) begin
          looped = 1'b0;
          continue;
        end
        looped = 1'b0;
        if (r == LOOP_MARK && v == LOOP_MARK) begin
          ptr = '0;
          looped = 1'b1;
          continue;
        end
        cnt = dly;
        w = '{kind: KIND_WRITE, regno: r, value: v, playing: 1'b1, last: 1'b0};
        batch.push_back(w);
      end
      if (commit) begin
        cursor = ptr;
        hold = cnt;
        running = on;
        after_loop = looped;
        if (batch.size() != 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) due_writes.push_back(batch[i]);
      end
      return -1;
    endfunction

    function void take_command(cmd_t cmd, logic [ADDR_W-1:0] addr, logic [7:0] data);
      chip_write_t w;
      case (cmd)
        CMD_LOAD: begin
          log_bytes[addr] = data;
          loaded[addr] = 1'b1;
        end
        CMD_START, CMD_STOP: begin
          running = (cmd == CMD_START);
          cursor = '0;
          hold = '0;
          after_loop = 1'b0;
          w = '{kind: KIND_CLEAR, regno: 8'h00, value: 8'h00, playing: running, last: 1'b1};
          due_writes.push_back(w);
        end
        default: begin
          void'(advance_frame(1'b1));
        end
      endcase
    endfunction

    task check_write(chip_write_t got);
      chip_write_t want;
      if (due_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected output kind=%0d reg=%02h val=%02h",
                                  got.kind, got.regno, got.value));
        return;
      end
      want = due_writes.pop_front();
      if (got.kind !== want.kind || got.regno !== want.regno || got.value !== want.value ||
          got.playing !== want.playing || got.last !== want.last)
        report_mismatch($sformatf(
          "got kind=%0d reg=%02h val=%02h playing=%0d last=%0d, want %0d %02h %02h %0d %0d",
          got.kind, got.regno, got.value, got.playing, got.last,
          want.kind, want.regno, want.value, want.playing, want.last));
    endtask
  endclass

endpackage

FILE: dv/tb_register_write_sequence_player.sv
`timescale 1ns / 1ps
// Bench top for register_write_sequence_player: directed and random command items, song
// length writes and a checker on every output strobe. Depends on rwsp_pkg, player_check_pkg.
module tb_register_write_sequence_player;
  import rwsp_pkg::*;
  import player_check_pkg::*;

  localparam int TARGET_ITEMS  = 410;
  localparam int SETTLE_CYCLES = 400;   // outlasts the longest tick
  localparam int CYCLE_LIMIT   = 1_500_000;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_cmd = CMD_TICK;
  logic [11:0]       in_load_addr = '0;
  logic [7:0]        in_load_byte = '0;
  logic              out_valid;
  logic              out_kind;
  logic [7:0]        out_write_reg;
  logic [7:0]        out_write_value;
  logic              out_now_playing;
  logic              out_last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LEN_W-1:0]  cfg_song_length = '0;

  player_scoreboard  sb;
  chip_write_t       seen;
  bit                pace;
  int                played;
  int                cycle_count;

  register_write_sequence_player i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_load_addr    (in_load_addr),
    .in_load_byte    (in_load_byte),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_write_reg   (out_write_reg),
    .out_write_value (out_write_value),
    .out_now_playing (out_now_playing),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_song_length (cfg_song_length)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // outputs sampled before this edge's updates land
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      seen = '{kind: out_kind, regno: out_write_reg, value: out_write_value,
               playing: out_now_playing, last: out_last};
      sb.check_write(seen);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** register_write_sequence_player: FAILED **");
    $finish;
  end

  // start stays high across back-to-back items; it is only lowered for a gap or by drain
  task automatic issue(cmd_t cmd, logic [ADDR_W-1:0] addr, logic [7:0] data);
    int gap;
    gap = pace ? int'($urandom_range(0, 15)) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_load_addr <= addr;
    in_load_byte <= data;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    played++;
    sb.take_command(cmd, addr, data);
  endtask

  // any log byte the tick would reach unloaded gets a byte first, small delays mostly
  task automatic send_tick();
    int a;
    logic [7:0] fill;
    a = sb.advance_frame(1'b0);
    while (a >= 0) begin
      case (a % PKT_BYTES)
        2:       fill = 8'($urandom_range(0, 3));
        3:       fill = 8'h00;
        default: fill = 8'($urandom_range(0, 255));
      endcase
      issue(CMD_LOAD, ADDR_W'(a), fill);
      a = sb.advance_frame(1'b0);
    end
    issue(CMD_TICK, ADDR_W'($urandom_range(0, STORE_DEPTH - 1)), 8'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.due_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_song_length(int len);
    cfg_valid <= 1'b1;
    cfg_song_length <= LEN_W'(len);
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.song_len = LEN_W'(len);
  endtask

  initial begin : main
    logic [7:0]  demo [12];
    logic [7:0]  pr;
    logic [7:0]  pv;
    logic [15:0] pd;
    int          len;
    int          roll;
    int          npk;
    int          phase;
    sb = new();
    played = 0;
    pace = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty song, stopped tick, address/byte extremes, loop with key-off skip,
    // then a zero-delay loop that runs into the per-tick write cap and carries over
    demo = '{8'hB3, 8'h11, 8'h01, 8'h00,
             8'h40, 8'h7F, 8'h00, 8'h00,
             LOOP_MARK, LOOP_MARK, 8'h00, 8'h00};
    set_song_length(0);
    issue(CMD_TICK, 12'hABC, 8'h5A);
    issue(CMD_STOP, 12'h000, 8'h00);
    issue(CMD_LOAD, 12'hFFF, 8'hFF);
    for (int i = 0; i < 12; i++) issue(CMD_LOAD, ADDR_W'(i), demo[i]);
    issue(CMD_START, 12'h000, 8'h00);
    issue(CMD_TICK, 12'h000, 8'h00);
    drain();
    set_song_length(12);
    issue(CMD_START, 12'h555, 8'hAA);
    issue(CMD_TICK, 12'h000, 8'h00);
    issue(CMD_TICK, 12'h000, 8'h00);
    issue(CMD_TICK, 12'h000, 8'h00);
    issue(CMD_STOP, 12'h000, 8'h00);

    phase = 0;
    while (played < TARGET_ITEMS) begin
      drain();
      case (phase)
        0:       len = STORE_DEPTH;
        1:       len = 0;
        2:       len = 3;
        default: len = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 80))
                                                    : 4 * int'($urandom_range(1, 16));
      endcase
      set_song_length(len);
      pace = ($urandom_range(0, 3) != 0);

      // fresh song of well-formed packets from address zero
      npk = $urandom_range(1, 12);
      for (int p = 0; p < npk; p++) begin
        roll = $urandom_range(0, 9);
        pr = 8'($urandom_range(0, 255));
        pv = 8'($urandom_range(0, 255));
        pd = 16'($urandom_range(0, 3));
        case (roll)
          0: begin
            pr = LOOP_MARK;
            pv = LOOP_MARK;
          end
          1, 2, 3: pr = 8'($urandom_range(KEYOFF_LO, KEYOFF_HI));
          4: if ($urandom_range(0, 3) == 0) pd = 16'($urandom_range(0, 16'hFFFF));
          5: pd = 16'($urandom_range(4, 40));
          6: pr = ($urandom_range(0, 1) != 0) ? 8'hAF : 8'hB9;
          default: ;
        endcase
        issue(CMD_LOAD, ADDR_W'(4 * p), pr);
        issue(CMD_LOAD, ADDR_W'(4 * p + 1), pv);
        issue(CMD_LOAD, ADDR_W'(4 * p + 2), pd[7:0]);
        issue(CMD_LOAD, ADDR_W'(4 * p + 3), pd[15:8]);
      end

      issue(CMD_START, ADDR_W'($urandom_range(0, STORE_DEPTH - 1)), 8'($urandom_range(0, 255)));
      repeat ($urandom_range(12, 32)) begin
        roll = $urandom_range(0, 99);
        if (roll < 74)
          send_tick();
        else if (roll < 86)
          issue(CMD_LOAD, ADDR_W'($urandom_range(0, STORE_DEPTH - 1)),
                8'($urandom_range(0, 255)));
        else if (roll < 94)
          issue(CMD_START, ADDR_W'($urandom_range(0, STORE_DEPTH - 1)),
                8'($urandom_range(0, 255)));
        else
          issue(CMD_STOP, ADDR_W'($urandom_range(0, STORE_DEPTH - 1)),
                8'($urandom_range(0, 255)));
      end
      phase++;
    end
    drain();

    if (sb.mismatches == 0)
      $display("** register_write_sequence_player: PASSED **");
    else
      $display("** register_write_sequence_player: FAILED **");
    $finish;
  end

endmodule
